@@ rtl/hct_pkg.sv @@
package hct_pkg;

   localparam int DEFAULT_DEPTH = 64;

   // Opcodes of the request word.
   localparam logic [2:0] OP_OBSERVE = 3'd0;
   localparam logic [2:0] OP_BLACK   = 3'd1;
   localparam logic [2:0] OP_WHITE   = 3'd2;
   localparam logic [2:0] OP_REMOVE  = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;
   localparam logic [2:0] OP_STANDBY = 3'd5;
   localparam logic [2:0] OP_READ    = 3'd6;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NO_ENTRY = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;

   localparam logic [7:0]  TONE_NONE = 8'hFF;
   localparam logic [9:0]  MS_CAP    = 10'd999;
   localparam logic [10:0] MS_PER_S  = 11'd1000;
   localparam logic [15:0] DUR_MAX   = 16'hFFFF;

   // Milliseconds to seconds: floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT
   // for every 32-bit x.
   localparam logic [28:0] RECIP_1000  = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;

   typedef struct packed {
      logic [31:0] freq;
      logic [31:0] settings;
      logic [15:0] last_open_s;
      logic [15:0] duration;
      logic [7:0]  tone;
      logic        digital;
      logic        open;
      logic        white;
      logic        black;
   } entry_type;

   typedef struct packed {
      logic shift_en;
      logic write_en;
      logic mark_en;
      logic close_all;
   } cell_ctl_type;

endpackage

@@ rtl/hct_cell.sv @@
module hct_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7,
   parameter int SW  = 6
) (
   input  logic                 clock,
   input  hct_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]        count,
   input  logic [31:0]          key,
   input  logic [SW-1:0]        shift_pos,
   input  logic [SW-1:0]        write_pos,
   input  logic [SW-1:0]        mark_pos,
   input  logic [SW-1:0]        sel_pos,
   input  logic                 use_match,
   input  hct_pkg::entry_type   nb_data,
   input  hct_pkg::entry_type   wr_data,
   input  logic [1:0]           mark_val,
   input  logic                 found_in,
   output logic                 found_out,
   output logic                 match,
   output logic                 evict,
   output logic                 sel,
   output hct_pkg::entry_type   data
);
   import hct_pkg::*;

   entry_type data_ff, data_in;
   logic      in_range, unmarked;

   assign data     = data_ff;
   assign in_range = CW'(IDX) < count;
   assign match    = in_range && (data_ff.freq == key);
   assign unmarked = in_range && !data_ff.white && !data_ff.black;
   // The first unmarked cell in the chain is the eviction victim.
   assign evict     = unmarked && !found_in;
   assign found_out = found_in || unmarked;
   assign sel       = use_match ? match : (sel_pos == SW'(IDX));

   always_comb begin
      data_in = data_ff;
      if (ctl.close_all) begin
         data_in.open = 1'b0;
      end
      if (ctl.shift_en && (SW'(IDX) >= shift_pos)) begin
         data_in = nb_data;
      end
      if (ctl.write_en && (write_pos == SW'(IDX))) begin
         data_in = wr_data;
      end
      if (ctl.mark_en && (mark_pos == SW'(IDX))) begin
         data_in.white = mark_val[0];
         data_in.black = mark_val[1];
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ rtl/heard_channel_table.sv @@
// Sequence: a request word is accepted in S_IDLE, the cell row is searched in S_LOOK
// and the results registered, and the request is executed in S_EXEC, which loads the
// response register once any earlier response has been taken.
// A new request is accepted only in S_IDLE, after the previous one has been executed;
// the sequencer sets the pace.
// Reset clears the entry count, the active and duration-owner slots, the
// time registers and the monitor bit; cell contents are left unknown.
module heard_channel_table #(
   parameter int TABLE_DEPTH = hct_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_freq,
   input  logic        req_carrier_open,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_tone_code,
   input  logic        req_tone_digital,
   input  logic        req_mark_black,
   input  logic [31:0] req_channel_settings,
   input  logic [5:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_entry_freq,
   output logic        rsp_entry_open,
   output logic [15:0] rsp_open_seconds,
   output logic [15:0] rsp_seconds_ago,
   output logic [7:0]  rsp_entry_tone,
   output logic        rsp_entry_digital,
   output logic [1:0]  rsp_marks,
   output logic [31:0] rsp_entry_settings,
   output logic [6:0]  rsp_entry_count,
   output logic signed [6:0] rsp_active_slot,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import hct_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = $clog2(TABLE_DEPTH);
   localparam int SW = (PW > 6) ? PW : 6;
   localparam int XW = (CW > SW) ? CW : SW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]  state_ff, state_in;

   logic [2:0]  op_ff;
   logic [31:0] freq_ff, now_ff, set_ff;
   logic        carrier_ff, digital_ff, markb_ff;
   logic [7:0]  tone_ff;
   logic [5:0]  sidx_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   last_check_ff, last_check_in;
   logic          act_v_ff, act_v_in;
   logic [SW-1:0] act_ff, act_in;
   logic          own_v_ff, own_v_in;
   logic [SW-1:0] own_ff, own_in;
   logic [9:0]    frac_ff, frac_in;
   logic          mon_ff;

   logic          hit_ff, ev_ff;
   logic [SW-1:0] hit_pos_ff, ev_pos_ff;
   entry_type     rd_ff;
   logic [15:0]   now_s_ff;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [5:0]  slot_ff;
   entry_type   ent_ff;
   logic [15:0] ago_ff;
   logic [6:0]  cnt_out_ff;
   logic [6:0]  act_out_ff;

   // Cell row wiring.
   entry_type    cell_data [TABLE_DEPTH];
   logic [TABLE_DEPTH:0] found;
   logic [TABLE_DEPTH-1:0] match_v, evict_v, sel_v;
   cell_ctl_type ctl;
   logic [SW-1:0] shift_pos, write_pos, mark_pos, sel_pos;
   logic          use_match;
   entry_type     wr_data;
   logic [1:0]    mark_val;

   logic          any_hit, any_ev;
   logic [SW-1:0] hit_pos, ev_pos;
   entry_type     rd_data;
   logic [60:0]   prod;

   logic          go;
   logic [1:0]    o_status;
   logic [SW-1:0] o_pos;
   logic          o_has;
   entry_type     o_ent;
   entry_type     none_ent;

   // Observe datapath.
   logic          full;
   entry_type     cur, upd;
   logic [SW-1:0] obs_pos;
   logic [31:0]   base_ms, dms;
   logic [9:0]    add_ms;
   logic [10:0]   fsum;
   logic          tick, eff;

   assign req_ready = (state_ff == S_IDLE);
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == CW'(TABLE_DEPTH));

   assign found[0]  = 1'b0;
   assign use_match = (op_ff == OP_OBSERVE);
   assign sel_pos   = ((op_ff == OP_BLACK) || (op_ff == OP_WHITE)) ? act_ff : SW'(sidx_ff);

   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      hct_cell #(.IDX(gi), .CW(CW), .SW(SW)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .key       (freq_ff),
         .shift_pos (shift_pos),
         .write_pos (write_pos),
         .mark_pos  (mark_pos),
         .sel_pos   (sel_pos),
         .use_match (use_match),
         .nb_data   (cell_data[(gi + 1 < TABLE_DEPTH) ? gi + 1 : gi]),
         .wr_data   (wr_data),
         .mark_val  (mark_val),
         .found_in  (found[gi]),
         .found_out (found[gi+1]),
         .match     (match_v[gi]),
         .evict     (evict_v[gi]),
         .sel       (sel_v[gi]),
         .data      (cell_data[gi])
      );
   end

   // Keys are unique, so match is one-hot; the found chain makes evict one-hot; both reduce by OR.
   always_comb begin
      any_hit = 1'b0;
      any_ev  = 1'b0;
      hit_pos = '0;
      ev_pos  = '0;
      rd_data = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         any_hit = any_hit | match_v[i];
         any_ev  = any_ev | evict_v[i];
         hit_pos = hit_pos | (match_v[i] ? SW'(i) : '0);
         ev_pos  = ev_pos | (evict_v[i] ? SW'(i) : '0);
         rd_data = rd_data | (sel_v[i] ? cell_data[i] : '0);
      end
   end

   assign prod = 61'(now_ff) * 61'(RECIP_1000);

   always_comb begin
      none_ent      = '0;
      none_ent.tone = TONE_NONE;
   end

   // Observe update on the found entry or on a freshly appended one.
   always_comb begin
      cur             = rd_ff;
      if (!hit_ff) begin
         cur             = '0;
         cur.freq        = freq_ff;
         cur.last_open_s = now_s_ff;
         cur.tone        = TONE_NONE;
         cur.open        = 1'b1;
      end
      obs_pos = hit_ff ? hit_pos_ff : (full ? SW'(TABLE_DEPTH - 1) : SW'(count_ff));
      base_ms = hit_ff ? last_check_ff : now_ff;
      dms     = now_ff - base_ms;
      add_ms  = (dms > 32'(MS_CAP)) ? MS_CAP : dms[9:0];
      fsum    = ((own_v_ff && (own_ff == obs_pos)) ? {1'b0, frac_ff} : 11'd0)
                + {1'b0, add_ms};
      tick    = (fsum >= MS_PER_S);
      eff     = carrier_ff && !(cur.black || (cur.white && !mon_ff));
      upd     = cur;
      if (cur.open && tick && (cur.duration != DUR_MAX)) begin
         upd.duration = cur.duration + 16'd1;
      end
      if (eff) begin
         upd.last_open_s = now_s_ff;
      end
      upd.open     = eff;
      upd.tone     = tone_ff;
      upd.digital  = digital_ff;
      upd.black    = cur.black || markb_ff;
      upd.settings = set_ff;
   end

   always_comb begin
      ctl           = '0;
      shift_pos     = ev_pos_ff;
      write_pos     = obs_pos;
      mark_pos      = act_ff;
      wr_data       = upd;
      mark_val      = (op_ff == OP_WHITE) ? 2'b01 : 2'b10;
      count_in      = count_ff;
      last_check_in = last_check_ff;
      act_v_in      = act_v_ff;
      act_in        = act_ff;
      own_v_in      = own_v_ff;
      own_in        = own_ff;
      frac_in       = frac_ff;
      o_status      = ST_DONE;
      o_pos         = '0;
      o_has         = 1'b0;
      o_ent         = rd_ff;
      case (op_ff)
         OP_OBSERVE: begin
            if (!hit_ff && (!carrier_ff || (full && !ev_ff))) begin
               o_status = ST_NO_ENTRY;
            end else begin
               ctl.write_en  = 1'b1;
               // A full table drops its victim and appends in the top cell.
               ctl.shift_en  = !hit_ff && full;
               if (!hit_ff && !full) begin
                  count_in = count_ff + CW'(1);
               end
               last_check_in = now_ff;
               if (cur.open) begin
                  own_v_in = 1'b1;
                  own_in   = obs_pos;
                  frac_in  = tick ? 10'(fsum - MS_PER_S) : fsum[9:0];
                  act_v_in = 1'b1;
                  act_in   = obs_pos;
               end
               o_has = 1'b1;
               o_pos = obs_pos;
               o_ent = upd;
            end
         end
         OP_BLACK, OP_WHITE: begin
            if (!act_v_ff || (XW'(act_ff) >= XW'(count_ff))) begin
               o_status = ST_NO_ENTRY;
            end else begin
               ctl.mark_en = 1'b1;
               o_has       = 1'b1;
               o_pos       = act_ff;
               o_ent.white = mark_val[0];
               o_ent.black = mark_val[1];
            end
         end
         OP_REMOVE: begin
            if (XW'(sidx_ff) >= XW'(count_ff)) begin
               o_status = ST_BAD_SLOT;
            end else begin
               ctl.shift_en = 1'b1;
               shift_pos    = SW'(sidx_ff);
               count_in     = count_ff - CW'(1);
               if (act_v_ff && (act_ff == SW'(sidx_ff))) begin
                  act_v_in = 1'b0;
               end else if (act_v_ff && (act_ff > SW'(sidx_ff))) begin
                  act_in = act_ff - SW'(1);
               end
               o_has = 1'b1;
               o_pos = SW'(sidx_ff);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            act_v_in = 1'b0;
         end
         OP_READ: begin
            if (XW'(sidx_ff) >= XW'(count_ff)) begin
               o_status = ST_BAD_SLOT;
            end else begin
               o_has = 1'b1;
               o_pos = SW'(sidx_ff);
            end
         end
         default: begin
            ctl.close_all = 1'b1;
            last_check_in = now_ff;
         end
      endcase
      if (!go) begin
         ctl = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_EXEC;
         S_EXEC: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         last_check_ff <= '0;
         act_v_ff      <= 1'b0;
         act_ff        <= '0;
         own_v_ff      <= 1'b0;
         own_ff        <= '0;
         frac_ff       <= '0;
         mon_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            mon_ff <= csr_wr_data;
         end
         if (go) begin
            count_ff      <= count_in;
            last_check_ff <= last_check_in;
            act_v_ff      <= act_v_in;
            act_ff        <= act_in;
            own_v_ff      <= own_v_in;
            own_ff        <= own_in;
            frac_ff       <= frac_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_opcode;
         freq_ff    <= req_freq;
         carrier_ff <= req_carrier_open;
         now_ff     <= req_now_ms;
         tone_ff    <= req_tone_code;
         digital_ff <= req_tone_digital;
         markb_ff   <= req_mark_black;
         set_ff     <= req_channel_settings;
         sidx_ff    <= req_slot_index;
      end
      if (state_ff == S_LOOK) begin
         hit_ff     <= any_hit;
         hit_pos_ff <= hit_pos;
         ev_ff      <= any_ev;
         ev_pos_ff  <= ev_pos;
         rd_ff      <= rd_data;
         now_s_ff   <= prod[RECIP_SHIFT +: 16];
      end
      if (go) begin
         status_ff  <= o_status;
         cnt_out_ff <= 7'(count_in);
         act_out_ff <= act_v_in ? 7'(act_in) : 7'h7F;
         if (o_has) begin
            slot_ff <= o_pos[5:0];
            ent_ff  <= o_ent;
            ago_ff  <= now_s_ff - o_ent.last_open_s;
         end else begin
            slot_ff <= '0;
            ent_ff  <= none_ent;
            ago_ff  <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_entry_freq     = ent_ff.freq;
   assign rsp_entry_open     = ent_ff.open;
   assign rsp_open_seconds   = ent_ff.duration;
   assign rsp_seconds_ago    = ago_ff;
   assign rsp_entry_tone     = ent_ff.tone;
   assign rsp_entry_digital  = ent_ff.digital;
   assign rsp_marks          = {ent_ff.black, ent_ff.white};
   assign rsp_entry_settings = ent_ff.settings;
   assign rsp_entry_count    = cnt_out_ff;
   assign rsp_active_slot    = act_out_ff;

endmodule
